// ===== sv/rtb_pkg.sv =====
package rtb_pkg;

  localparam int SLOTS_DEF = 32;
  localparam logic [15:0] HALF_CAP_MS = 16'd30000;
  localparam logic [9:0] US_PER_MS = 10'd1000;

  typedef enum logic [1:0] {
    FN_SCHED  = 2'd0,
    FN_ACK    = 2'd1,
    FN_CANCEL = 2'd2,
    FN_COLLECT = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_NOTFND  = 3'd2,
    ST_DUE     = 3'd3,
    ST_DONE    = 3'd4,
    ST_BACK    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_REAP,
    S_EMIT,
    S_MUL,
    S_OUT
  } state_t;

  // slot record as held in the memory
  typedef struct packed {
    logic [15:0] source;
    logic [63:0] message;
    logic [63:0] expiry;
    logic [63:0] next_due;
    logic [15:0] backoff;
    logic [7:0]  attempts;
    logic [7:0]  limit;
  } slot_t;

  function automatic logic [15:0] next_backoff(input logic [15:0] cur);
    logic [15:0] c;
    c = (cur > HALF_CAP_MS) ? HALF_CAP_MS : cur;
    next_backoff = (c == 16'd0) ? 16'd1 : {c[14:0], 1'b0};
  endfunction

endpackage

// ===== sv/retry_table_exponential_backoff.sv =====
// Retransmission table with exponential backoff. Items enter on in_*; results
// leave on out_*, the final word of each input marked by out_tlast. The slot
// records live in one memory with a write port and a registered read port.
// Schedule picks the lowest free slot from the valid bits. Acknowledge and
// cancel walk the slots one per cycle unless a held result word stalls them,
// and stop at the first matching slot. A collect makes a pass that drops
// expired and exhausted entries, then a pass that emits up to out_limit due
// entries; each emitted entry takes a backoff update and multiply, then a
// write-back of the record, and waits while the consumer stalls out_tready.
// One item is handled at a time.
module retry_table_exponential_backoff #(
  parameter int SLOTS = rtb_pkg::SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // func[1:0], src[17:2], msg[81:18], expiry[145:82],
  // attempt_limit[153:146], backoff_ms[169:154], now[233:170],
  // out_limit[239:234]
  input  logic [239:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], slot_index[8:3], due_source[24:9], due_message[88:25],
  // attempt[96:89], collected_count[102:97], active_count[108:103],
  // acks_count[140:109], retries_count[172:141], expired_count[204:173],
  // exhausted_count[236:205], zero fill [239:237]
  output logic [239:0] out_tdata,
  output logic         out_tlast
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // memory
  rtb_pkg::slot_t mem [SLOTS];
  rtb_pkg::slot_t rd_q;
  logic           we;
  logic [IW-1:0]  waddr, raddr;
  rtb_pkg::slot_t wdat;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdat;
    end
    rd_q <= mem[raddr];
  end

  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [5:0]  occ_r, occ_nxt;
  logic [63:0] lct_r, lct_nxt;
  logic [31:0] acks_r, acks_nxt, retr_r, retr_nxt, expd_r, expd_nxt, exh_r, exh_nxt;
  rtb_pkg::state_t st_r, st_nxt;

  logic [239:0] in_q_r, in_q_nxt;
  logic [CW-1:0] idx_r, idx_nxt;        // slot being read (issued)
  logic          rdv_r, rdv_nxt;        // rd_q holds slot idx_r-1
  logic          pass2_r, pass2_nxt;
  logic [5:0]    coll_r, coll_nxt;
  rtb_pkg::slot_t rec_r, rec_nxt;
  logic [IW-1:0] rslot_r, rslot_nxt;
  logic [25:0]   prod_r, prod_nxt;

  logic [239:0] o_data_r, o_data_nxt;
  logic         o_last_r, o_last_nxt, o_v_r, o_v_nxt;

  rtb_pkg::func_t fn;
  logic [15:0] f_src;
  logic [63:0] f_msg, f_exp, f_now;
  logic [7:0]  f_lim;
  logic [15:0] f_bo;
  logic [5:0]  f_cap;
  assign fn    = rtb_pkg::func_t'(in_q_r[1:0]);
  assign f_src = in_q_r[17:2];
  assign f_msg = in_q_r[81:18];
  assign f_exp = in_q_r[145:82];
  assign f_lim = in_q_r[153:146];
  assign f_bo  = in_q_r[169:154];
  assign f_now = in_q_r[233:170];
  assign f_cap = in_q_r[239:234];

  assign in_tready  = (st_r == rtb_pkg::S_IDLE);
  assign out_tvalid = o_v_r;
  assign out_tdata  = o_data_r;
  assign out_tlast  = o_last_r;

  logic [IW-1:0] cur;
  logic [64:0]   due_sum;
  assign cur = idx_r[IW-1:0] - IW'(1);
  assign due_sum = {1'b0, f_now} + {39'd0, prod_r};

  function automatic logic [239:0] pack(
    input rtb_pkg::status_t s, input logic [5:0] slot, input logic [15:0] src,
    input logic [63:0] msg, input logic [7:0] att, input logic [5:0] col,
    input logic [5:0] occ, input logic [31:0] a, input logic [31:0] r,
    input logic [31:0] e, input logic [31:0] x);
    pack = {3'd0, x, e, r, a, occ, col, att, msg, src, slot, s};
  endfunction

  always_comb begin
    st_nxt = st_r; valid_nxt = valid_r; occ_nxt = occ_r; lct_nxt = lct_r;
    acks_nxt = acks_r; retr_nxt = retr_r; expd_nxt = expd_r; exh_nxt = exh_r;
    in_q_nxt = in_q_r; idx_nxt = idx_r; rdv_nxt = 1'b0; pass2_nxt = pass2_r;
    coll_nxt = coll_r; rec_nxt = rec_r; rslot_nxt = rslot_r; prod_nxt = prod_r;
    o_data_nxt = o_data_r; o_last_nxt = o_last_r;
    o_v_nxt = o_v_r && !out_tready;
    we = 1'b0; waddr = '0; wdat = rec_r; raddr = idx_r[IW-1:0];
    unique case (st_r)
      rtb_pkg::S_IDLE: begin
        if (in_tvalid) begin
          in_q_nxt = in_tdata;
          idx_nxt = '0; pass2_nxt = 1'b0; coll_nxt = '0;
          st_nxt = rtb_pkg::S_SCAN;
        end
      end
      rtb_pkg::S_SCAN: begin
        // result slot must be free before any word is produced
        if (!o_v_nxt) begin
          unique case (fn) inside
            rtb_pkg::FN_SCHED: begin
              st_nxt = rtb_pkg::S_IDLE; o_v_nxt = 1'b1; o_last_nxt = 1'b1;
              o_data_nxt = pack(rtb_pkg::ST_FULL, '0, '0, '0, '0, '0, occ_r,
                                acks_r, retr_r, expd_r, exh_r);
              for (int i = SLOTS - 1; i >= 0; i--) begin
                if (!valid_r[i]) begin
                  waddr = IW'(i);
                  o_data_nxt = pack(rtb_pkg::ST_OK, 6'(i), '0, '0, '0, '0,
                                    occ_r + 6'd1, acks_r, retr_r, expd_r, exh_r);
                end
              end
              if (!(&valid_r)) begin
                we = 1'b1;
                wdat = '{source: f_src, message: f_msg, expiry: f_exp,
                         next_due: f_now, backoff: f_bo, attempts: 8'd0,
                         limit: f_lim};
                valid_nxt[waddr] = 1'b1; occ_nxt = occ_r + 6'd1;
              end
            end
            rtb_pkg::FN_ACK, rtb_pkg::FN_CANCEL: begin
              if (rdv_r && valid_r[cur] && rd_q.source == f_src
                  && rd_q.message == f_msg) begin
                valid_nxt[cur] = 1'b0; occ_nxt = occ_r - 6'd1;
                if (fn == rtb_pkg::FN_ACK) acks_nxt = acks_r + 32'd1;
                o_data_nxt = pack(rtb_pkg::ST_OK, 6'(cur), '0, '0, '0, '0,
                                  occ_nxt, acks_nxt, retr_r, expd_r, exh_r);
                o_v_nxt = 1'b1; o_last_nxt = 1'b1; st_nxt = rtb_pkg::S_IDLE;
              end else if (idx_r == CW'(SLOTS)) begin
                o_data_nxt = pack(rtb_pkg::ST_NOTFND, '0, '0, '0, '0, '0, occ_r,
                                  acks_r, retr_r, expd_r, exh_r);
                o_v_nxt = 1'b1; o_last_nxt = 1'b1; st_nxt = rtb_pkg::S_IDLE;
              end else begin
                idx_nxt = idx_r + CW'(1); rdv_nxt = 1'b1;
              end
            end
            default: begin
              if (f_now < lct_r) begin
                o_data_nxt = pack(rtb_pkg::ST_BACK, '0, '0, '0, '0, '0, occ_r,
                                  acks_r, retr_r, expd_r, exh_r);
                o_v_nxt = 1'b1; o_last_nxt = 1'b1; st_nxt = rtb_pkg::S_IDLE;
              end else begin
                lct_nxt = f_now; st_nxt = rtb_pkg::S_REAP;
                idx_nxt = CW'(1); raddr = '0; rdv_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      rtb_pkg::S_REAP: begin
        // pass one drops, pass two emits; rd_q holds slot cur
        if (!pass2_r) begin
          if (valid_r[cur]) begin
            if (rd_q.expiry != 64'd0 && f_now >= rd_q.expiry) begin
              valid_nxt[cur] = 1'b0; occ_nxt = occ_r - 6'd1;
              expd_nxt = expd_r + 32'd1;
            end else if (rd_q.attempts >= rd_q.limit) begin
              valid_nxt[cur] = 1'b0; occ_nxt = occ_r - 6'd1;
              exh_nxt = exh_r + 32'd1;
            end
          end
          if (idx_r == CW'(SLOTS)) begin
            pass2_nxt = 1'b1; idx_nxt = CW'(1); raddr = '0;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
          rdv_nxt = 1'b1;
        end else if (coll_r < f_cap && valid_r[cur] && rd_q.next_due <= f_now) begin
          rec_nxt = rd_q; rslot_nxt = cur; st_nxt = rtb_pkg::S_EMIT;
        end else if (idx_r == CW'(SLOTS) || coll_r >= f_cap) begin
          st_nxt = rtb_pkg::S_OUT;
        end else begin
          idx_nxt = idx_r + CW'(1); rdv_nxt = 1'b1;
        end
      end
      rtb_pkg::S_EMIT: begin
        rec_nxt.attempts = rec_r.attempts + 8'd1;
        rec_nxt.backoff = rtb_pkg::next_backoff(rec_r.backoff);
        prod_nxt = 26'(rec_nxt.backoff) * 26'(rtb_pkg::US_PER_MS);
        st_nxt = rtb_pkg::S_MUL;
      end
      rtb_pkg::S_MUL: begin
        if (!o_v_nxt) begin
          we = 1'b1; waddr = rslot_r;
          wdat = rec_r;
          wdat.next_due = due_sum[64] ? '1 : due_sum[63:0];
          coll_nxt = coll_r + 6'd1; retr_nxt = retr_r + 32'd1;
          o_data_nxt = pack(rtb_pkg::ST_DUE, 6'(rslot_r), rec_r.source,
                            rec_r.message, rec_r.attempts, '0, occ_r, acks_r,
                            retr_nxt, expd_r, exh_r);
          o_v_nxt = 1'b1; o_last_nxt = 1'b0;
          if (idx_r == CW'(SLOTS) || coll_nxt >= f_cap) begin
            st_nxt = rtb_pkg::S_OUT;
          end else begin
            st_nxt = rtb_pkg::S_REAP; raddr = idx_r[IW-1:0];
            idx_nxt = idx_r + CW'(1); rdv_nxt = 1'b1;
          end
        end
      end
      rtb_pkg::S_OUT: begin
        if (!o_v_nxt) begin
          o_data_nxt = pack(rtb_pkg::ST_DONE, '0, '0, '0, '0, coll_r, occ_r,
                            acks_r, retr_r, expd_r, exh_r);
          o_v_nxt = 1'b1; o_last_nxt = 1'b1; st_nxt = rtb_pkg::S_IDLE;
        end
      end
      default: st_nxt = rtb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rtb_pkg::S_IDLE; valid_r <= '0; occ_r <= '0; lct_r <= '0;
      acks_r <= '0; retr_r <= '0; expd_r <= '0; exh_r <= '0;
      o_v_r <= 1'b0; rdv_r <= 1'b0;
    end else begin
      st_r <= st_nxt; valid_r <= valid_nxt; occ_r <= occ_nxt; lct_r <= lct_nxt;
      acks_r <= acks_nxt; retr_r <= retr_nxt; expd_r <= expd_nxt; exh_r <= exh_nxt;
      o_v_r <= o_v_nxt; rdv_r <= rdv_nxt;
    end
    in_q_r <= in_q_nxt; idx_r <= idx_nxt; pass2_r <= pass2_nxt; coll_r <= coll_nxt;
    rec_r <= rec_nxt; rslot_r <= rslot_nxt; prod_r <= prod_nxt;
    o_data_r <= o_data_nxt; o_last_r <= o_last_nxt;
  end

`ifndef NO_ASSERTIONS
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == 6'($countones(valid_r))) else $error("occupancy mismatch");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("second item taken");
`endif

endmodule
